// ===== design/serial_command_frame_parser_unit_defines.svh =====
// assertion macros for the serial command frame parser checker
// no dependencies; included by files that hold concurrent assertions
`ifndef SERIAL_COMMAND_FRAME_PARSER_UNIT_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SFP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sfp_pkg.sv =====
// shared types and codes for the serial command frame parser
// no dependencies
package sfp_pkg;

	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		ST_TAKEN = 2'd0,
		ST_DROP  = 2'd1,
		ST_GOOD  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEADER  = 2'd0,
		CFG_TRAILER = 2'd1,
		CFG_CTL_LIM = 2'd2,
		CFG_LVL_LIM = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] header_byte;
		logic [BYTE_W-1:0] trailer_byte;
		logic [BYTE_W-1:0] control_limit;
		logic [BYTE_W-1:0] level_limit;
	} cfg_t;

	// bytes kept across the frame
	typedef struct packed {
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] ctl;
		logic [BYTE_W-1:0] lvl;
		logic [BYTE_W-1:0] chk;
	} hold_t;

	typedef struct packed {
		status_t           status;
		logic [BYTE_W-1:0] control_value;
		logic [BYTE_W-1:0] level_value;
	} res_t;

endpackage

// ===== design/sfp_cfg_regs.sv =====
// configuration register file of the frame parser
// depends on sfp_pkg
module sfp_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfp_pkg::BYTE_W-1:0]     cfg_data,
	output sfp_pkg::cfg_t                  cfg
);
	import sfp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte   <= 8'h5A;
			cfg_q.trailer_byte  <= 8'hA5;
			cfg_q.control_limit <= 8'd2;
			cfg_q.level_limit   <= 8'd100;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_HEADER:  cfg_q.header_byte   <= cfg_data;
				CFG_TRAILER: cfg_q.trailer_byte  <= cfg_data;
				CFG_CTL_LIM: cfg_q.control_limit <= cfg_data;
				CFG_LVL_LIM: cfg_q.level_limit   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/sfp_parse.sv =====
// per-byte frame parsing logic: next frame state and result
// depends on sfp_pkg
module sfp_parse #(
	parameter int FRAME_LEN = 6,
	parameter int CNT_W     = $clog2(FRAME_LEN + 1)
) (
	input  sfp_pkg::cfg_t              cfg,
	input  logic [sfp_pkg::BYTE_W-1:0] rx_byte,
	input  logic [CNT_W-1:0]           cnt,
	input  sfp_pkg::hold_t             hold,
	output logic [CNT_W-1:0]           cnt_nxt,
	output sfp_pkg::hold_t             hold_nxt,
	output sfp_pkg::res_t              res
);
	import sfp_pkg::*;

	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_LEN);
	localparam logic [CNT_W-1:0] CHK_POS  = CNT_W'(FRAME_LEN - 2);
	localparam logic [CNT_W-1:0] CTL_POS  = CNT_W'(1);
	localparam logic [CNT_W-1:0] LVL_POS  = CNT_W'(2);

	hold_t            upd;
	logic [CNT_W-1:0] cnt_inc;
	logic             fail;

	always_comb begin
		upd     = hold;
		cnt_inc = cnt + CNT_W'(1);
		if (cnt < CHK_POS) upd.sum = hold.sum + rx_byte;
		if (cnt == CTL_POS) upd.ctl = rx_byte;
		if (cnt == LVL_POS) upd.lvl = rx_byte;
		if (cnt == CHK_POS) upd.chk = rx_byte;
		fail = (cnt_inc != LAST_CNT) || (upd.chk != upd.sum);

		cnt_nxt  = '0;
		hold_nxt = '0;
		res      = '{status: ST_TAKEN, control_value: '0, level_value: '0};

		if ((cnt == '0 && rx_byte != cfg.header_byte) || cnt == LAST_CNT) begin
			res.status = ST_DROP;
		end else if (rx_byte != cfg.trailer_byte) begin
			cnt_nxt  = cnt_inc;
			hold_nxt = upd;
		end else if (fail) begin
			res.status = ST_DROP;
		end else if (upd.ctl > cfg.control_limit || upd.lvl > cfg.level_limit) begin
			res.status = ST_RANGE;
		end else begin
			res.status        = ST_GOOD;
			res.control_value = upd.ctl;
			res.level_value   = upd.lvl;
		end
	end

endmodule

// ===== design/serial_command_frame_parser_unit.sv =====
// top level of the serial command frame parser
// depends on sfp_pkg, sfp_cfg_regs and sfp_parse
//
//  channel | signals                                 | direction
//  rx      | rx_valid, rx_stall, rx_byte             | byte request in
//  res     | res_valid, res_stall, status, ctl, lvl  | result request out
//  cfg     | cfg_we, cfg_index, cfg_data             | register write in
//
// one result per accepted byte; a byte can be taken every cycle while rx_stall is low
// each byte passes through the input register, then parse logic into the result register
// the frame state updates when a byte moves from the input register to the result register
// rx_stall rises only while both the input register and the result register are full
// and the result side stalls; reset clears the frame state and both valid flags
module serial_command_frame_parser_unit #(
	parameter int FRAME_LEN = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// byte input
	input  logic                          rx_valid,
	output logic                          rx_stall,
	input  logic [sfp_pkg::BYTE_W-1:0]    rx_byte,
	// result output
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [1:0]                    status,
	output logic [sfp_pkg::BYTE_W-1:0]    control_value,
	output logic [sfp_pkg::BYTE_W-1:0]    level_value,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfp_pkg::BYTE_W-1:0]    cfg_data
);
	import sfp_pkg::*;

	// counter must hold FRAME_LEN itself (frame overran without a trailer)
	localparam int CNT_W = $clog2(FRAME_LEN + 1);

	cfg_t cfg;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// frame state
	logic [CNT_W-1:0]  cnt_q;
	hold_t             hold_q;

	// parse logic outputs
	logic [CNT_W-1:0]  cnt_nxt;
	hold_t             hold_nxt;
	res_t              res_nxt;

	// result register
	logic              valid_s2;
	res_t              res_s2;

	logic              advance;

	sfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfp_parse #(
		.FRAME_LEN (FRAME_LEN),
		.CNT_W     (CNT_W)
	) u_parse (
		.cfg      (cfg),
		.rx_byte  (byte_s1),
		.cnt      (cnt_q),
		.hold     (hold_q),
		.cnt_nxt  (cnt_nxt),
		.hold_nxt (hold_nxt),
		.res      (res_nxt)
	);

	// byte moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!valid_s2 || !res_stall);
	assign rx_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// frame state, advanced once per parsed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			hold_q <= '0;
		end else if (advance) begin
			cnt_q  <= cnt_nxt;
			hold_q <= hold_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			res_s2   <= '{status: ST_TAKEN, control_value: '0, level_value: '0};
		end else if (advance) begin
			valid_s2 <= 1'b1;
			res_s2   <= res_nxt;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	assign res_valid     = valid_s2;
	assign status        = res_s2.status;
	assign control_value = res_s2.control_value;
	assign level_value   = res_s2.level_value;

endmodule

// ===== design/sfp_checker.sv =====
// port-level checker for the serial command frame parser, bound to the top level
// depends on sfp_pkg and serial_command_frame_parser_unit_defines.svh
`include "serial_command_frame_parser_unit_defines.svh"

module sfp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rx_stall,
	input logic                          res_valid,
	input logic                          res_stall,
	input logic [1:0]                    status,
	input logic [sfp_pkg::BYTE_W-1:0]    control_value,
	input logic [sfp_pkg::BYTE_W-1:0]    level_value
);
	import sfp_pkg::*;

	`SFP_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid,
		"result request dropped while stalled")

	`SFP_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(status),
		"result status changed while stalled")

	`SFP_ASSERT_NOW(a_values_zero, res_valid && status != ST_GOOD,
		control_value == '0 && level_value == '0,
		"frame values nonzero without a good frame")

	`SFP_ASSERT_NOW(a_stall_cause, rx_stall, res_valid && res_stall,
		"byte input stalled while result side is free")

endmodule

bind serial_command_frame_parser_unit sfp_checker u_sfp_checker (.*);
